FILE: hw/rtl/tos_pkg.sv
// ============================================================================
// Telnet option stripper package
// Byte codes, parser phase codes, capability flag positions, reply codes,
// register indexes and register reset values shared by the option stripper logic.
// ============================================================================
package tos_pkg;

   // Telnet command bytes
   localparam logic [7:0] B_IAC  = 8'd255;
   localparam logic [7:0] B_DONT = 8'd254;
   localparam logic [7:0] B_DO   = 8'd253;
   localparam logic [7:0] B_WONT = 8'd252;
   localparam logic [7:0] B_WILL = 8'd251;
   localparam logic [7:0] B_SB   = 8'd250;
   localparam logic [7:0] B_SE   = 8'd240;

   // Fixed option codes
   localparam logic [7:0] OPT_NAWS  = 8'd31;
   localparam logic [7:0] OPT_TTYPE = 8'd24;

   // Parser phases
   localparam logic [2:0] PH_DATA   = 3'd0;
   localparam logic [2:0] PH_IAC    = 3'd1;
   localparam logic [2:0] PH_OPT    = 3'd2;
   localparam logic [2:0] PH_SBOPT  = 3'd3;
   localparam logic [2:0] PH_SBDATA = 3'd4;
   localparam logic [2:0] PH_SBIAC  = 3'd5;

   // Capability flag bit positions
   localparam int FL_TTYPE = 0;
   localparam int FL_NAWS  = 1;
   localparam int FL_MSDP  = 2;
   localparam int FL_MSSP  = 3;
   localparam int FL_MXP   = 4;
   localparam int FL_MSP   = 5;
   localparam int FL_ATCP  = 6;
   localparam int FLAG_W   = 7;

   // Reply codes
   typedef logic [1:0] reply_type;
   localparam reply_type REPLY_NONE  = 2'd0;
   localparam reply_type REPLY_TTYPE = 2'd1;
   localparam reply_type REPLY_MXP   = 2'd2;
   localparam reply_type REPLY_MSSP  = 2'd3;

   // Configuration register indexes
   localparam logic [2:0] REG_MSDP = 3'd0;
   localparam logic [2:0] REG_MSSP = 3'd1;
   localparam logic [2:0] REG_MXP  = 3'd2;
   localparam logic [2:0] REG_MSP  = 3'd3;
   localparam logic [2:0] REG_ATCP = 3'd4;

   // Configuration register reset values
   localparam logic [7:0] MSDP_RESET = 8'd69;
   localparam logic [7:0] MSSP_RESET = 8'd70;
   localparam logic [7:0] MXP_RESET  = 8'd91;
   localparam logic [7:0] MSP_RESET  = 8'd90;
   localparam logic [7:0] ATCP_RESET = 8'd200;

   // Subnegotiation byte counter saturates here
   localparam logic [2:0] SUB_COUNT_MAX = 3'd7;

endpackage

FILE: hw/rtl/telnet_option_stripper_core.sv
// ============================================================================
// Telnet option stripper core
// Strips telnet commands from a received byte stream, tracks negotiated
// capabilities and NAWS window size, and raises one-beat reply codes.
// ============================================================================
// The block takes one received byte per beat on the req_ channel and returns
// exactly one result beat per byte on the rsp_ channel, in order. A byte
// is held in the input register until the result register can take a
// result, is parsed by a single step of the telnet state machine, and is
// then loaded into the result register. A new byte is taken every cycle
// unless the consumer holds rsp_stall, the only thing that slows it. Plain
// bytes outside commands and IAC IAC come out with data_valid set; all
// other bytes come out with data_valid clear and data_byte zero. The
// capability flags and window size are those after the byte of that beat.
// The option codes for MSDP, MSSP, MXP, MSP and ATCP are programmable over
// the csr_ port and should only be changed while no byte is in flight.
// Parser state carries across any split of the byte stream.
module telnet_option_stripper_core
   import tos_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   // Received byte channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,

   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_data_valid,
   output logic [7:0]  rsp_data_byte,
   output logic [1:0]  rsp_reply_code,
   output logic [6:0]  rsp_capability_flags,
   output logic [15:0] rsp_window_width,
   output logic [15:0] rsp_window_height,

   // Configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // ------------------------------------------------------------------------
   // Configuration registers. Registers sit at byte addresses 0, 4, 8, 12
   // and 16; the word index is taken from paddr[4:2].
   // ------------------------------------------------------------------------
   logic [7:0] msdp_opt_ff, mssp_opt_ff, mxp_opt_ff, msp_opt_ff, atcp_opt_ff;
   logic       csr_write;
   logic [2:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         msdp_opt_ff <= MSDP_RESET;
         mssp_opt_ff <= MSSP_RESET;
         mxp_opt_ff  <= MXP_RESET;
         msp_opt_ff  <= MSP_RESET;
         atcp_opt_ff <= ATCP_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_MSDP: msdp_opt_ff <= csr_pwdata[7:0];
            REG_MSSP: mssp_opt_ff <= csr_pwdata[7:0];
            REG_MXP:  mxp_opt_ff  <= csr_pwdata[7:0];
            REG_MSP:  msp_opt_ff  <= csr_pwdata[7:0];
            REG_ATCP: atcp_opt_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Read data is combinational from the address, zero-extended to 32 bits.
   always_comb begin
      case (csr_index)
         REG_MSDP: csr_prdata = {24'd0, msdp_opt_ff};
         REG_MSSP: csr_prdata = {24'd0, mssp_opt_ff};
         REG_MXP:  csr_prdata = {24'd0, mxp_opt_ff};
         REG_MSP:  csr_prdata = {24'd0, msp_opt_ff};
         REG_ATCP: csr_prdata = {24'd0, atcp_opt_ff};
         default:  csr_prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Handshake. The input register holds one byte; it is parsed when the
   // result register is empty or is being emptied in the same cycle. The
   // input side is stalled only when the input register is full and cannot
   // drain, so a new byte is taken every cycle while the output flows.
   // ------------------------------------------------------------------------
   logic       in_full_ff, in_full_in;
   logic [7:0] in_byte_ff;
   logic       out_full_ff, out_full_in;
   logic       out_move;
   logic       proc;
   logic       req_take;

   assign out_move  = ~out_full_ff | ~rsp_stall;
   assign proc      = in_full_ff & out_move;
   assign req_stall = in_full_ff & ~out_move;
   assign req_take  = req_valid & ~req_stall;

   assign in_full_in  = req_take | (in_full_ff & ~proc);
   assign out_full_in = proc | (out_full_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_full_ff  <= 1'b0;
         out_full_ff <= 1'b0;
      end else begin
         in_full_ff  <= in_full_in;
         out_full_ff <= out_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // ------------------------------------------------------------------------
   // Parser state
   // ------------------------------------------------------------------------
   logic [2:0]        phase_ff, phase_in;
   logic              will_ff, will_in;
   logic [7:0]        sub_opt_ff, sub_opt_in;
   logic [2:0]        sub_count_ff, sub_count_in;
   logic [FLAG_W-1:0] flags_ff, flags_in;
   logic [15:0]       width_ff, width_in;
   logic [15:0]       height_ff, height_in;

   // First four subnegotiation data bytes; entries are only read after they
   // have been written in the same subnegotiation, so they need no reset.
   logic [7:0]        head_ff [4];
   logic              head_we;

   // Result of this step
   logic              dvalid_in;
   logic [7:0]        dbyte_in;
   reply_type         reply_in;
   logic              keep_byte;

   always_comb begin
      phase_in     = phase_ff;
      will_in      = will_ff;
      sub_opt_in   = sub_opt_ff;
      sub_count_in = sub_count_ff;
      flags_in     = flags_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      dvalid_in    = 1'b0;
      dbyte_in     = 8'd0;
      reply_in     = REPLY_NONE;
      keep_byte    = 1'b0;

      case (phase_ff)
         PH_DATA: begin
            if (in_byte_ff == B_IAC) begin
               phase_in = PH_IAC;
            end else begin
               dvalid_in = 1'b1;
               dbyte_in  = in_byte_ff;
            end
         end

         PH_IAC: begin
            if (in_byte_ff == B_IAC) begin
               dvalid_in = 1'b1;
               dbyte_in  = B_IAC;
               phase_in  = PH_DATA;
            end else if (in_byte_ff == B_SB) begin
               phase_in = PH_SBOPT;
            end else if (in_byte_ff inside {[B_WILL:B_DONT]}) begin
               will_in  = (in_byte_ff == B_WILL);
               phase_in = PH_OPT;
            end else begin
               phase_in = PH_DATA;
            end
         end

         PH_OPT: begin
            // Only WILL acts; the first matching option code wins.
            if (will_ff) begin
               if (in_byte_ff == OPT_TTYPE) begin
                  reply_in = REPLY_TTYPE;
               end else if (in_byte_ff == OPT_NAWS) begin
                  flags_in[FL_NAWS] = 1'b1;
               end else if (in_byte_ff == msdp_opt_ff) begin
                  flags_in[FL_MSDP] = 1'b1;
               end else if (in_byte_ff == mssp_opt_ff) begin
                  flags_in[FL_MSSP] = 1'b1;
               end else if (in_byte_ff == mxp_opt_ff) begin
                  flags_in[FL_MXP] = 1'b1;
                  reply_in         = REPLY_MXP;
               end else if (in_byte_ff == msp_opt_ff) begin
                  flags_in[FL_MSP] = 1'b1;
               end else if (in_byte_ff == atcp_opt_ff) begin
                  flags_in[FL_ATCP] = 1'b1;
               end
            end
            will_in  = 1'b0;
            phase_in = PH_DATA;
         end

         PH_SBOPT: begin
            sub_opt_in   = in_byte_ff;
            sub_count_in = 3'd0;
            phase_in     = PH_SBDATA;
         end

         PH_SBDATA: begin
            if (in_byte_ff == B_IAC) begin
               phase_in = PH_SBIAC;
            end else begin
               keep_byte = 1'b1;
            end
         end

         PH_SBIAC: begin
            if (in_byte_ff == B_SE) begin
               // End of subnegotiation: act on the option collected.
               if (sub_opt_ff == OPT_TTYPE) begin
                  if (sub_count_ff > 3'd1 && head_ff[0] == 8'd0) begin
                     flags_in[FL_TTYPE] = 1'b1;
                  end
               end else if (sub_opt_ff == OPT_NAWS && sub_count_ff >= 3'd4) begin
                  width_in          = {head_ff[0], head_ff[1]};
                  height_in         = {head_ff[2], head_ff[3]};
                  flags_in[FL_NAWS] = 1'b1;
               end else if (sub_opt_ff == msdp_opt_ff && sub_count_ff >= 3'd2) begin
                  // Server data protocol payload is not interpreted.
               end else if (sub_opt_ff == mssp_opt_ff) begin
                  reply_in = REPLY_MSSP;
               end
               phase_in = PH_DATA;
            end else begin
               keep_byte = 1'b1;
               phase_in  = PH_SBDATA;
            end
         end

         default: begin
            phase_in = PH_DATA;
         end
      endcase

      // Subnegotiation data byte: store the first four, count up to saturation.
      if (keep_byte && sub_count_ff != SUB_COUNT_MAX) begin
         sub_count_in = sub_count_ff + 3'd1;
      end
   end

   assign head_we = keep_byte & ~sub_count_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DATA;
         will_ff      <= 1'b0;
         sub_opt_ff   <= 8'd0;
         sub_count_ff <= 3'd0;
         flags_ff     <= '0;
         width_ff     <= 16'd0;
         height_ff    <= 16'd0;
      end else if (proc) begin
         phase_ff     <= phase_in;
         will_ff      <= will_in;
         sub_opt_ff   <= sub_opt_in;
         sub_count_ff <= sub_count_in;
         flags_ff     <= flags_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc && head_we) begin
         head_ff[sub_count_ff[1:0]] <= in_byte_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Result register. The parser state only advances when a result is
   // loaded, so the flags and window size held in state always equal the
   // values after the byte of the beat currently presented.
   // ------------------------------------------------------------------------
   logic       dvalid_ff;
   logic [7:0] dbyte_ff;
   reply_type  reply_ff;

   always_ff @(posedge clock) begin
      if (proc) begin
         dvalid_ff <= dvalid_in;
         dbyte_ff  <= dbyte_in;
         reply_ff  <= reply_in;
      end
   end

   assign rsp_valid            = out_full_ff;
   assign rsp_data_valid       = dvalid_ff;
   assign rsp_data_byte        = dbyte_ff;
   assign rsp_reply_code       = reply_ff;
   assign rsp_capability_flags = flags_ff;
   assign rsp_window_width     = width_ff;
   assign rsp_window_height    = height_ff;

endmodule

FILE: tb/tb_telnet_option_stripper_core.sv
// ============================================================================
// Telnet option stripper core testbench
// Streams received telnet bytes through the core under random valid and stall
// pressure, predicts every result beat from its own model of the telnet
// parser and checks each field, across several sets of option codes.
// ============================================================================
module tb_telnet_option_stripper_core
   import tos_pkg::*;
();

   // Cycles without any accepted beat before the run is abandoned. The longest
   // legitimate quiet stretch is a long stall or gap plus the register writes
   // between settings, so this is generous.
   localparam int WATCHDOG_LIMIT = 5000;
   // Random bytes queued for each set of option codes.
   localparam int BYTES_PER_SETTING = 170;

   // One expected result beat.
   typedef struct packed {
      logic             data_valid;
      logic [7:0]       data_byte;
      reply_type        reply_code;
      logic [FLAG_W-1:0] flags;
      logic [15:0]      width;
      logic [15:0]      height;
   } parsed_type;

   // -------------------------------------------------------------------------
   // Clock, reset and the signals of the block. Every input has a known value
   // from time zero.
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'd0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_data_valid;
   logic [7:0]  rsp_data_byte;
   logic [1:0]  rsp_reply_code;
   logic [6:0]  rsp_capability_flags;
   logic [15:0] rsp_window_width;
   logic [15:0] rsp_window_height;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = 5'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   always #5 clock = ~clock;

   telnet_option_stripper_core u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_data_valid       (rsp_data_valid),
      .rsp_data_byte        (rsp_data_byte),
      .rsp_reply_code       (rsp_reply_code),
      .rsp_capability_flags (rsp_capability_flags),
      .rsp_window_width     (rsp_window_width),
      .rsp_window_height    (rsp_window_height),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   // -------------------------------------------------------------------------
   // Parser model. It mirrors the state of the core and is advanced once per
   // accepted request beat. Reset is applied only once, so the declared
   // initial values stand for the state after reset.
   // -------------------------------------------------------------------------
   logic [2:0]        parse_ph = PH_DATA;
   logic              will_pending = 1'b0;
   logic [7:0]        sub_opt = 8'd0;
   logic [2:0]        sub_len = 3'd0;
   logic [7:0]        sub_head [4];
   logic [FLAG_W-1:0] caps = '0;
   logic [15:0]       win_w = 16'd0;
   logic [15:0]       win_h = 16'd0;

   // Model copy of the programmable option codes.
   logic [7:0] msdp_code = MSDP_RESET;
   logic [7:0] mssp_code = MSSP_RESET;
   logic [7:0] mxp_code  = MXP_RESET;
   logic [7:0] msp_code  = MSP_RESET;
   logic [7:0] atcp_code = ATCP_RESET;

   logic [7:0] rx_stream [$];    // bytes waiting to be offered to the core
   parsed_type parsed_q [$];     // predicted results, oldest first
   logic [7:0] opening_bytes [30];

   int mismatches = 0;
   int beats_seen = 0;
   int quiet_cycles = 0;
   int gap_left = 0;
   int stall_left = 0;
   int in_calm = 0;
   int out_calm = 0;

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // Only the first four subnegotiation bytes are stored; the length counter
   // saturates so that long subnegotiations still read as long.
   function automatic void keep_sub_byte(input logic [7:0] b);
      if (sub_len < 3'd4)
         sub_head[sub_len[1:0]] = b;
      if (sub_len < SUB_COUNT_MAX)
         sub_len = sub_len + 3'd1;
   endfunction

   // Advances the parser model by one received byte and queues the result
   // that the core must return for it.
   function automatic void parse_byte(input logic [7:0] b);
      parsed_type r;
      r = '0;
      case (parse_ph)
         PH_DATA: begin
            if (b == B_IAC) parse_ph = PH_IAC;
            else begin
               r.data_valid = 1'b1;
               r.data_byte  = b;
            end
         end
         PH_IAC: begin
            if (b == B_IAC) begin
               // An escaped IAC is a literal 255 in the user data.
               r.data_valid = 1'b1;
               r.data_byte  = B_IAC;
               parse_ph     = PH_DATA;
            end else if (b == B_SB) begin
               parse_ph = PH_SBOPT;
            end else if (b == B_WILL || b == B_WONT || b == B_DO || b == B_DONT) begin
               will_pending = (b == B_WILL);
               parse_ph     = PH_OPT;
            end else begin
               // Any other command byte is simply dropped.
               parse_ph = PH_DATA;
            end
         end
         PH_OPT: begin
            // Only WILL acts on its option; the fixed codes win over the
            // programmable ones, which are tried in register order.
            if (will_pending) begin
               if (b == OPT_TTYPE) r.reply_code = REPLY_TTYPE;
               else if (b == OPT_NAWS) caps[FL_NAWS] = 1'b1;
               else if (b == msdp_code) caps[FL_MSDP] = 1'b1;
               else if (b == mssp_code) caps[FL_MSSP] = 1'b1;
               else if (b == mxp_code) begin
                  caps[FL_MXP] = 1'b1;
                  r.reply_code = REPLY_MXP;
               end
               else if (b == msp_code) caps[FL_MSP] = 1'b1;
               else if (b == atcp_code) caps[FL_ATCP] = 1'b1;
            end
            will_pending = 1'b0;
            parse_ph     = PH_DATA;
         end
         PH_SBOPT: begin
            sub_opt  = b;
            sub_len  = 3'd0;
            parse_ph = PH_SBDATA;
         end
         PH_SBDATA: begin
            if (b == B_IAC) parse_ph = PH_SBIAC;
            else keep_sub_byte(b);
         end
         PH_SBIAC: begin
            if (b == B_SE) begin
               if (sub_opt == OPT_TTYPE) begin
                  // TTYPE IS needs the IS byte and at least one more.
                  if (sub_len > 3'd1 && sub_head[0] == 8'd0) caps[FL_TTYPE] = 1'b1;
               end else if (sub_opt == OPT_NAWS && sub_len >= 3'd4) begin
                  win_w = {sub_head[0], sub_head[1]};
                  win_h = {sub_head[2], sub_head[3]};
                  caps[FL_NAWS] = 1'b1;
               end else if (sub_opt == msdp_code && sub_len >= 3'd2) begin
                  // A real MSDP payload shadows an MSSP match and does nothing.
               end else if (sub_opt == mssp_code) begin
                  r.reply_code = REPLY_MSSP;
               end
               parse_ph = PH_DATA;
            end else begin
               // A stray IAC inside a subnegotiation is dropped and the byte
               // after it is kept as data; IAC IAC keeps one 255.
               keep_sub_byte(b);
               parse_ph = PH_SBDATA;
            end
         end
         default: parse_ph = PH_DATA;
      endcase
      r.flags  = caps;
      r.width  = win_w;
      r.height = win_h;
      parsed_q.push_back(r);
   endfunction

   // -------------------------------------------------------------------------
   // Random pauses for both channels: mostly none or short, a few long, and
   // now and then a calm stretch with no pauses at all.
   // -------------------------------------------------------------------------
   function automatic int pick_pause(inout int calm);
      int r;
      r = $urandom_range(0, 999);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if (r < 5) begin
         calm = $urandom_range(50, 200);
         return 0;
      end
      if (r < 600) return 0;
      if (r < 900) return $urandom_range(1, 3);
      if (r < 985) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Option codes are chosen so that the fixed and programmable matches are
   // hit often, together with the extremes and arbitrary values.
   function automatic logic [7:0] pick_option();
      case ($urandom_range(0, 9))
         0: return OPT_TTYPE;
         1: return OPT_NAWS;
         2: return msdp_code;
         3: return mssp_code;
         4: return mxp_code;
         5: return msp_code;
         6: return atcp_code;
         7: return 8'd0;
         8: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Request driver. A byte is held on the port until it is accepted; the
   // model is advanced at the same edge, so its order always matches the core.
   // Each output gets at most one nonblocking assignment per edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      logic free;
      if (reset) begin
         req_valid <= 1'b0;
         req_rx_byte <= 8'd0;
         gap_left = 0;
      end else begin
         free = !req_valid;
         if (req_valid && !req_stall) begin
            parse_byte(req_rx_byte);
            free = 1'b1;
         end
         if (free) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (rx_stream.size() != 0) begin
               req_valid   <= 1'b1;
               req_rx_byte <= rx_stream.pop_front();
               gap_left = pick_pause(in_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result monitor. Every accepted result beat is checked field by field
   // against the oldest prediction; the stall is raised at random.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      parsed_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            beats_seen++;
            if (parsed_q.size() == 0) begin
               report_mismatch($sformatf("result beat %0d arrived with no byte outstanding",
                                         beats_seen));
            end else begin
               e = parsed_q.pop_front();
               if (rsp_data_valid !== e.data_valid)
                  report_mismatch($sformatf("beat %0d data_valid got %0d expected %0d",
                                            beats_seen, rsp_data_valid, e.data_valid));
               if (rsp_data_byte !== e.data_byte)
                  report_mismatch($sformatf("beat %0d data_byte got 0x%0h expected 0x%0h",
                                            beats_seen, rsp_data_byte, e.data_byte));
               if (rsp_reply_code !== e.reply_code)
                  report_mismatch($sformatf("beat %0d reply_code got %0d expected %0d",
                                            beats_seen, rsp_reply_code, e.reply_code));
               if (rsp_capability_flags !== e.flags)
                  report_mismatch($sformatf("beat %0d capability_flags got 0x%0h expected 0x%0h",
                                            beats_seen, rsp_capability_flags, e.flags));
               if (rsp_window_width !== e.width)
                  report_mismatch($sformatf("beat %0d window_width got %0d expected %0d",
                                            beats_seen, rsp_window_width, e.width));
               if (rsp_window_height !== e.height)
                  report_mismatch($sformatf("beat %0d window_height got %0d expected %0d",
                                            beats_seen, rsp_window_height, e.height));
            end
         end
         if (stall_left == 0) stall_left = pick_pause(out_calm);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: ends the run if neither channel moves a beat for too long.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Register access. A write (setup then access) is followed directly by a
   // read of the same register, whose data is checked in its access cycle.
   // -------------------------------------------------------------------------
   task automatic write_option(input logic [2:0] idx, input logic [7:0] code);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {24'd0, code};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[7:0] !== code)
         report_mismatch($sformatf("register %0d read back 0x%0h after writing 0x%0h",
                                   idx, csr_prdata[7:0], code));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_MSDP: msdp_code = code;
         REG_MSSP: mssp_code = code;
         REG_MXP:  mxp_code  = code;
         REG_MSP:  msp_code  = code;
         REG_ATCP: atcp_code = code;
         default: ;
      endcase
   endtask

   task automatic load_codes(input logic [7:0] msdp, input logic [7:0] mssp,
                             input logic [7:0] mxp, input logic [7:0] msp,
                             input logic [7:0] atcp);
      write_option(REG_MSDP, msdp);
      write_option(REG_MSSP, mssp);
      write_option(REG_MXP, mxp);
      write_option(REG_MSP, msp);
      write_option(REG_ATCP, atcp);
   endtask

   // Waits until every queued byte has been accepted and every predicted
   // result has come back, then lets the pipeline settle.
   task automatic wait_idle();
      while (rx_stream.size() != 0 || req_valid || parsed_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Queues roughly n bytes, mostly well-formed telnet sequences with random
   // content, plus stray commands, unterminated subnegotiations and noise.
   task automatic add_random(input int n);
      int goal;
      int len;
      int r;
      logic [7:0] b;
      goal = rx_stream.size() + n;
      while (rx_stream.size() < goal) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            // Plain text, with any 255 escaped.
            len = $urandom_range(1, 6);
            repeat (len) begin
               b = 8'($urandom_range(0, 255));
               rx_stream.push_back(b);
               if (b == B_IAC) rx_stream.push_back(B_IAC);
            end
         end else if (r < 55) begin
            // Option negotiation, WILL twice as often as the others.
            rx_stream.push_back(B_IAC);
            case ($urandom_range(0, 4))
               0, 1: rx_stream.push_back(B_WILL);
               2: rx_stream.push_back(B_WONT);
               3: rx_stream.push_back(B_DO);
               default: rx_stream.push_back(B_DONT);
            endcase
            rx_stream.push_back(pick_option());
         end else if (r < 85) begin
            // Subnegotiation of up to seven data bytes; one in ten is left open.
            rx_stream.push_back(B_IAC);
            rx_stream.push_back(B_SB);
            rx_stream.push_back(pick_option());
            len = $urandom_range(0, 7);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(0, 9))
                  0: begin
                     rx_stream.push_back(B_IAC);
                     rx_stream.push_back(B_IAC);
                  end
                  1: begin
                     // Stray IAC followed by an ordinary byte.
                     do b = 8'($urandom_range(0, 255));
                     while (b == B_SE || b == B_IAC);
                     rx_stream.push_back(B_IAC);
                     rx_stream.push_back(b);
                  end
                  default: begin
                     if (i == 0 && $urandom_range(0, 1) == 0) b = 8'd0;
                     else b = 8'($urandom_range(0, 254));
                     rx_stream.push_back(b);
                  end
               endcase
            end
            if ($urandom_range(0, 9) != 0) begin
               rx_stream.push_back(B_IAC);
               rx_stream.push_back(B_SE);
            end
         end else if (r < 92) begin
            // IAC with an arbitrary command byte.
            rx_stream.push_back(B_IAC);
            rx_stream.push_back(8'($urandom_range(0, 255)));
         end else begin
            rx_stream.push_back(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Test sequence.
   // -------------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Opening sequence with the reset option codes: the smallest byte,
      // escaped IAC, an unknown command, WILL TTYPE, a NAWS subnegotiation
      // carrying an escaped 255, TTYPE IS and an empty MSSP subnegotiation.
      opening_bytes = '{8'h00, B_IAC, B_IAC, B_IAC, 8'hF1, B_IAC, B_WILL, OPT_TTYPE,
                        B_IAC, B_SB, OPT_NAWS, 8'h00, 8'h50, B_IAC, B_IAC, 8'h00,
                        B_IAC, B_SE, B_IAC, B_SB, OPT_TTYPE, 8'h00, 8'h41, B_IAC,
                        B_SE, B_IAC, B_SB, MSSP_RESET, B_IAC, B_SE};
      foreach (opening_bytes[i]) rx_stream.push_back(opening_bytes[i]);
      add_random(BYTES_PER_SETTING);
      wait_idle();

      // All codes at the low extreme, so every programmable code collides.
      load_codes(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      add_random(BYTES_PER_SETTING);
      wait_idle();

      // All codes at the high extreme, which is also the IAC value.
      load_codes(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      add_random(BYTES_PER_SETTING);
      wait_idle();

      // Programmable codes shadowed by the fixed NAWS and TTYPE codes, and
      // three registers sharing one code so that MXP must win.
      load_codes(OPT_NAWS, OPT_TTYPE, 8'd100, 8'd100, 8'd100);
      add_random(BYTES_PER_SETTING);
      wait_idle();

      // MSDP and MSSP sharing a code: only short subnegotiations report.
      load_codes(8'd150, 8'd150, 8'd151, 8'd152, 8'd153);
      add_random(BYTES_PER_SETTING);
      wait_idle();

      load_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
      add_random(BYTES_PER_SETTING);
      wait_idle();

      // Back to the usual codes, written explicitly this time.
      load_codes(MSDP_RESET, MSSP_RESET, MXP_RESET, MSP_RESET, ATCP_RESET);
      add_random(BYTES_PER_SETTING);
      wait_idle();

      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
